FILE: rtl/bpi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpi_pkg: shared types and constants
// Field structs, request struct between front and back, list constants.
// ----------------------------------------------------------------------------
package bpi_pkg;

  localparam int LIST_DEPTH  = 4096;
  localparam int MAX_WORDS   = 65536;
  localparam int ALPHABET    = 26;
  localparam int NUM_BIGRAMS = ALPHABET * ALPHABET;
  localparam int NUM_LISTS   = NUM_BIGRAMS + ALPHABET;
  localparam int LIST_W      = $clog2(NUM_LISTS);
  localparam int BIGRAM_W    = $clog2(NUM_BIGRAMS);
  localparam int COUNT_W     = $clog2(LIST_DEPTH + 1);
  localparam int WORDC_W     = $clog2(MAX_WORDS + 1);

  typedef struct packed {
    logic [4:0] letter;
    logic       end_of_word;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  list_index;
    logic [15:0] word_id;
    logic [11:0] slot;
    logic        overflow;
    logic        last;
  } out_item_t;

  // One posting request from the front end
  typedef struct packed {
    logic [LIST_W-1:0]  list;
    logic               is_bigram;
    logic [WORDC_W-1:0] word;
    logic               last;
  } post_req_t;

endpackage : bpi_pkg
`default_nettype wire

FILE: rtl/bigram_posting_indexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bigram_posting_indexer: top level
// Front classifier feeds a posting engine over a one-entry request handoff.
//
//  channel | handshake      | payload
//  input   | push / full    | in_data  (letter, end_of_word)
//  result  | empty / pop    | out_data (list_index, word_id, slot, overflow, last)
//
// Each posting takes the engine through take, read and update, and output,
// and it returns to take once pop comes; a dropped repeat returns after read
// and update. The engine takes no new request before then. The front takes a
// new letter in the cycle after its last posting is handed over. After reset
// the engine clears its count and tag memories; a letter that posts during
// that pass holds full high until it ends. The result register holds while
// pop is low, stalling the front through the request handoff.
// ----------------------------------------------------------------------------
module bigram_posting_indexer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bpi_pkg::in_item_t  in_data,
  input  wire logic               push,
  output logic                    full,
  output bpi_pkg::out_item_t      out_data,
  output logic                    empty,
  input  wire logic               pop
);
  import bpi_pkg::*;

  post_req_t req;
  logic      req_valid, req_ready;

  bpi_front u_front (
    .clk(clk), .rst(rst), .in_data(in_data), .push(push), .full(full),
    .req(req), .req_valid(req_valid), .req_ready(req_ready)
  );

  bpi_back u_back (
    .clk(clk), .rst(rst), .req(req), .req_valid(req_valid),
    .req_ready(req_ready), .out_data(out_data), .empty(empty), .pop(pop)
  );

endmodule : bigram_posting_indexer
`default_nettype wire

FILE: rtl/bpi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpi_front: letter classifier
// Tracks word position and emits up to three posting requests per letter,
// one request per cycle while req_ready is high, over the request handoff.
// ----------------------------------------------------------------------------
module bpi_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bpi_pkg::in_item_t   in_data,
  input  wire logic                push,
  output logic                     full,
  output bpi_pkg::post_req_t       req,
  output logic                     req_valid,
  input  wire logic                req_ready
);
  import bpi_pkg::*;

  logic [4:0]         first_letter;
  logic [4:0]         prior_letter;
  logic [1:0]         letters_seen;
  logic [WORDC_W-1:0] word_counter;

  // Held item being expanded
  logic                 busy;
  logic [1:0]           n_req;
  logic [1:0]           idx;
  post_req_t            reqs [3];

  logic [4:0]           c;
  logic                 accept;
  logic [1:0]           n_new;
  post_req_t            new_reqs [3];
  logic [LIST_W-1:0]    uni_first, uni_c, bi;

  assign full   = busy;
  assign accept = push && !busy;

  // Clamp and build requests
  always_comb begin
    c = (in_data.letter >= 5'(ALPHABET)) ? 5'(ALPHABET - 1) : in_data.letter;
    uni_first = LIST_W'(NUM_BIGRAMS) + LIST_W'(first_letter);
    uni_c     = LIST_W'(NUM_BIGRAMS) + LIST_W'(c);
    bi        = LIST_W'(prior_letter) * LIST_W'(ALPHABET) + LIST_W'(c);
    for (int i = 0; i < 3; i++) begin
      new_reqs[i] = '0;
      new_reqs[i].word = word_counter;
    end
    n_new = 2'd0;
    if (letters_seen == 2'd0) begin
      if (in_data.end_of_word) begin
        new_reqs[0].list = uni_c;
        n_new = 2'd1;
      end
    end else if (letters_seen == 2'd1 && in_data.end_of_word) begin
      new_reqs[0].list = uni_first;
      if (c != first_letter) begin
        new_reqs[1].list = uni_c;
        new_reqs[2].list = bi;
        new_reqs[2].is_bigram = 1'b1;
        n_new = 2'd3;
      end else begin
        new_reqs[1].list = bi;
        new_reqs[1].is_bigram = 1'b1;
        n_new = 2'd2;
      end
    end else begin
      new_reqs[0].list = bi;
      new_reqs[0].is_bigram = 1'b1;
      n_new = 2'd1;
    end
  end

  always_comb begin
    req       = reqs[idx];
    req.last  = (idx == n_req - 2'd1);
    req_valid = busy;
  end

  // Advance word state and request sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= 2'd0;
      n_req <= 2'd0;
      first_letter <= '0;
      prior_letter <= '0;
      letters_seen <= '0;
      word_counter <= '0;
    end else begin
      if (busy && req_ready) begin
        if (idx == n_req - 2'd1) busy <= 1'b0;
        idx <= idx + 2'd1;
      end
      if (accept) begin
        reqs  <= new_reqs;
        n_req <= n_new;
        idx   <= 2'd0;
        busy  <= (n_new != 2'd0);
        if (in_data.end_of_word) begin
          if (word_counter < WORDC_W'(MAX_WORDS)) word_counter <= word_counter + 1'b1;
          letters_seen <= '0;
          prior_letter <= '0;
          first_letter <= '0;
        end else begin
          if (letters_seen == 2'd0) first_letter <= c;
          prior_letter <= c;
          if (letters_seen < 2'd2) letters_seen <= letters_seen + 2'd1;
        end
      end
    end
  end

endmodule : bpi_front
`default_nettype wire

FILE: rtl/bpi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpi_back: posting engine
// Reads list count and bigram tag memories, filters repeats, writes back,
// and delivers results through an output register.
// ----------------------------------------------------------------------------
module bpi_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bpi_pkg::post_req_t  req,
  input  wire logic                req_valid,
  output logic                     req_ready,
  output bpi_pkg::out_item_t       out_data,
  output logic                     empty,
  input  wire logic                pop
);
  import bpi_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state;

  logic [COUNT_W-1:0] count_mem [NUM_LISTS];
  logic [WORDC_W:0]   tag_mem   [NUM_BIGRAMS];   // msb is valid
  logic [COUNT_W-1:0] count_rd;
  logic [WORDC_W:0]   tag_rd;
  logic [LIST_W-1:0]  clr_addr;
  post_req_t          cur;

  logic               exhausted, repeated, ovf;

  assign req_ready = (state == S_IDLE);
  assign empty     = (state != S_OUT);

  always_comb begin
    exhausted = (cur.word >= WORDC_W'(MAX_WORDS));
    repeated  = cur.is_bigram && !exhausted && tag_rd[WORDC_W] &&
                (tag_rd[WORDC_W-1:0] == cur.word);
    ovf       = exhausted || (count_rd >= COUNT_W'(LIST_DEPTH));
  end

  // Memory reads
  always_ff @(posedge clk) begin
    count_rd <= count_mem[req.list];
    tag_rd   <= tag_mem[BIGRAM_W'(req.list)];
  end

  // Clear pass and posting writes
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      count_mem[clr_addr] <= '0;
      if (clr_addr < LIST_W'(NUM_BIGRAMS)) tag_mem[BIGRAM_W'(clr_addr)] <= '0;
    end else if (state == S_READ) begin
      if (cur.is_bigram && !exhausted) tag_mem[BIGRAM_W'(cur.list)] <= {1'b1, cur.word};
      if (!repeated && !ovf) count_mem[cur.list] <= count_rd + 1'b1;
    end
  end

  // Sequence requests; drop a repeated bigram
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LIST_W'(NUM_LISTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (repeated) begin
            state <= S_IDLE;
          end else begin
            out_data.list_index <= 10'(cur.list);
            out_data.word_id    <= exhausted ? 16'd0 : 16'(cur.word);
            out_data.slot       <= ovf ? 12'd0 : 12'(count_rd);
            out_data.overflow   <= ovf;
            out_data.last       <= cur.last;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (pop) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule : bpi_back
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for bigram_posting_indexer
// Drives letter streams through the push/full side, pops postings at random
// and compares each one against a posting tracker that mirrors list counts,
// bigram tags and word numbering, including list saturation and word number
// exhaustion.
// ----------------------------------------------------------------------------
module tb;
  import bpi_pkg::*;

  localparam int WATCH_LIMIT = 4000;

  // Posting tracker: mirrors the indexer state and holds pending postings
  class posting_tracker;
    int unsigned list_fill[NUM_LISTS];
    int unsigned tag_word[NUM_BIGRAMS];
    bit          tag_ok[NUM_BIGRAMS];
    int unsigned word_num;
    int unsigned head_letter;
    int unsigned prev_letter;
    int unsigned letter_cnt;
    out_item_t   pending[$];
    int          errors;

    function new();
      word_num = 0;
      head_letter = 0;
      prev_letter = 0;
      letter_cnt = 0;
      errors = 0;
      foreach (list_fill[i]) list_fill[i] = 0;
      foreach (tag_ok[i]) begin
        tag_ok[i] = 0;
        tag_word[i] = 0;
      end
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    function void post(int unsigned list, ref out_item_t batch[$]);
      out_item_t p;
      p.list_index = list[9:0];
      p.last = 1'b0;
      if (word_num >= MAX_WORDS) begin
        p.word_id = '0;
        p.slot = '0;
        p.overflow = 1'b1;
      end else if (list_fill[list] >= LIST_DEPTH) begin
        p.word_id = word_num[15:0];
        p.slot = '0;
        p.overflow = 1'b1;
      end else begin
        p.word_id = word_num[15:0];
        p.slot = list_fill[list][11:0];
        p.overflow = 1'b0;
        list_fill[list]++;
      end
      batch.push_back(p);
    endfunction

    function void post_bigram(int unsigned a, int unsigned b, ref out_item_t batch[$]);
      int unsigned bi;
      bi = a * ALPHABET + b;
      if (word_num < MAX_WORDS) begin
        // drop a bigram this word already posted
        if (tag_ok[bi] && tag_word[bi] == word_num) return;
        tag_ok[bi] = 1'b1;
        tag_word[bi] = word_num;
      end
      post(bi, batch);
    endfunction

    // Note one accepted input transaction and queue its postings
    function void note_letter(in_item_t it);
      int unsigned c;
      out_item_t batch[$];
      c = (it.letter >= ALPHABET) ? ALPHABET - 1 : it.letter;
      if (letter_cnt == 0) begin
        head_letter = c;
        if (it.end_of_word) post(NUM_BIGRAMS + c, batch);
      end else if (letter_cnt == 1) begin
        if (it.end_of_word) begin
          post(NUM_BIGRAMS + head_letter, batch);
          if (c != head_letter) post(NUM_BIGRAMS + c, batch);
        end
        post_bigram(prev_letter, c, batch);
      end else begin
        post_bigram(prev_letter, c, batch);
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) pending.push_back(batch[i]);
      if (it.end_of_word) begin
        if (word_num < MAX_WORDS) word_num++;
        letter_cnt = 0;
        prev_letter = 0;
        head_letter = 0;
      end else begin
        prev_letter = c;
        if (letter_cnt < 2) letter_cnt++;
      end
    endfunction

    // Check one accepted result transaction against the oldest posting
    task check_posting(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected posting list=%0d word=%0d",
                         got.list_index, got.word_id));
        return;
      end
      exp = pending.pop_front();
      if (got.list_index !== exp.list_index)
        report($sformatf("list_index %0d, want %0d", got.list_index, exp.list_index));
      if (got.word_id !== exp.word_id)
        report($sformatf("word_id %0d, want %0d", got.word_id, exp.word_id));
      if (got.slot !== exp.slot)
        report($sformatf("slot %0d, want %0d", got.slot, exp.slot));
      if (got.overflow !== exp.overflow)
        report($sformatf("overflow %0b, want %0b", got.overflow, exp.overflow));
      if (got.last !== exp.last)
        report($sformatf("last %0b, want %0b", got.last, exp.last));
    endtask
  endclass

  logic      clk;
  logic      rst;
  in_item_t  in_data;
  logic      push;
  logic      full;
  out_item_t out_data;
  logic      empty;
  logic      pop;

  posting_tracker tracker;
  int idle_in;
  int idle_out;
  int letters_sent;
  int quiet_cycles;

  bigram_posting_indexer dut (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .push     (push),
    .full     (full),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Observe both handshakes at the edge
  always @(posedge clk) begin
    if (!rst && push && !full) tracker.note_letter(in_data);
    if (!rst && pop && !empty) tracker.check_posting(out_data);
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
        tracker.report("timeout, no transaction");
        $display("bigram_posting_indexer: mismatch");
        $finish;
      end
    end
  end

  // Receiver: stall at random
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= idle_out);
    end
  end

  // Send one letter; hold push until accepted
  task send_letter(int unsigned ltr, bit eow);
      bit taken;
    if ($urandom_range(99) < idle_in) begin
      push <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    push <= 1'b1;
    in_data.letter <= ltr[4:0];
    in_data.end_of_word <= eow;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end
    letters_sent++;
  endtask

  task send_word(int unsigned w[$]);
    foreach (w[i]) send_letter(w[i], i == w.size() - 1);
  endtask

  // Random word: mostly short, letters mostly in range, some repeats
  task send_random_word();
    int unsigned w[$];
    int len;
    int r;
    r = $urandom_range(99);
    len = (r < 25) ? 1 : (r < 55) ? 2 : $urandom_range(8, 3);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) w.push_back($urandom_range(31, 26));
      else if (i >= 2 && $urandom_range(3) == 0) w.push_back(w[i-2]);
      else w.push_back($urandom_range(25));
    end
    send_word(w);
  endtask

  // Hold off the sender until every posting has come back
  task drain();
    push <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    in_data = '0;
    idle_in = 0;
    idle_out = 0;
    letters_sent = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words: unigrams, clamped letters, pairs, repeated bigrams
    send_word('{0});
    send_word('{31});
    send_word('{25});
    send_word('{0, 1});
    send_word('{3, 3});
    send_word('{1, 28});
    send_word('{0, 1, 0, 1});
    send_word('{7, 7, 7, 7});
    send_word('{30, 2, 16, 8, 4});
    drain();

    // Random words under each idling mix
    idle_in = 22;
    idle_out = 76;
    while (letters_sent < 180) send_random_word();
    idle_in = 76;
    idle_out = 22;
    while (letters_sent < 330) send_random_word();
    drain();
    idle_in = 0;
    idle_out = 0;
    while (letters_sent < 455) send_random_word();

    push <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("bigram_posting_indexer: match");
    end else begin
      $display("bigram_posting_indexer: mismatch");
    end
    $finish;
  end
endmodule

FILE: bigram_posting_indexer.f
rtl/bpi_pkg.sv
rtl/bpi_front.sv
rtl/bpi_back.sv
rtl/bigram_posting_indexer.sv
bench/tb.sv
